@@ rtl/core/crff_pkg.sv @@
// ----------------------------------------------------------------------------
// crff_pkg: shared types and clipping function for the rectangle fill engine
// Command and result payloads, queue entries, mask registers and the
// per-part clipping against the mask box and the screen.
// ----------------------------------------------------------------------------
package crff_pkg;

    // command modes as they arrive on the input
    localparam logic [1:0] MODE_RECT  = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MASK_LEFT   = 2'd0;
    localparam logic [1:0] REG_MASK_TOP    = 2'd1;
    localparam logic [1:0] REG_MASK_WIDTH  = 2'd2;
    localparam logic [1:0] REG_MASK_HEIGHT = 2'd3;

    localparam int NUM_PARTS = 4;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic signed [11:0] extent_w;
        logic signed [11:0] extent_h;
        logic [10:0]        border_px;
        logic [31:0]        fill_color;
    } cmd_t;

    typedef struct packed {
        logic        write_valid;
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [31:0] pixel_value;
        logic        last_write;
    } result_t;

    typedef enum logic [1:0] {
        KIND_RECT,
        KIND_FRAME,
        KIND_STEP
    } kind_t;

    // unclipped geometry of one part
    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic signed [13:0] w;
        logic signed [13:0] h;
    } part_t;

    typedef struct packed {
        kind_t                      kind;
        part_t [NUM_PARTS-1:0]      parts;
        logic  [NUM_PARTS-1:0]      part_en;
        logic  [31:0]               color;
    } entry_t;

    typedef struct packed {
        logic [10:0] left;
        logic [10:0] top;
        logic [11:0] width;
        logic [11:0] height;
    } mask_t;

    typedef struct packed {
        logic        valid;
        logic [10:0] x;
        logic [10:0] y;
        logic [11:0] x_end;
        logic [11:0] y_end;
    } clip_t;

    typedef struct packed {
        logic busy;
        logic load_pend;
        logic step_fire;
        logic last;
    } status_t;

    // screen size is 13 bits wide so that 2048 fits
    function automatic clip_t clip_part(part_t p, mask_t m, logic [12:0] scr_w,
                                        logic [12:0] scr_h);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic signed [15:0] ml;
        logic signed [15:0] mt;
        logic signed [15:0] mr;
        logic signed [15:0] mb;
        logic signed [15:0] sw;
        logic signed [15:0] sh;
        logic               drop;
        clip_t              c;
        x  = {{2{p.x[13]}}, p.x};
        y  = {{2{p.y[13]}}, p.y};
        w  = {{2{p.w[13]}}, p.w};
        h  = {{2{p.h[13]}}, p.h};
        ml = $signed({5'b0, m.left});
        mt = $signed({5'b0, m.top});
        mr = ml + $signed({4'b0, m.width});
        mb = mt + $signed({4'b0, m.height});
        sw = $signed({3'b0, scr_w});
        sh = $signed({3'b0, scr_h});
        // move the origin onto the mask
        if (x < ml)
        begin
            w = w - (ml - x);
            x = ml;
        end
        if (y < mt)
        begin
            h = h - (mt - y);
            y = mt;
        end
        drop = (x > sw) || (y > sh);
        if (x + w > mr)
        begin
            w = mr - x;
        end
        if (y + h > mb)
        begin
            h = mb - y;
        end
        if (x + w > sw)
        begin
            w = sw - x;
        end
        if (y + h > sh)
        begin
            h = sh - y;
        end
        c.valid = !drop && (w > 16'sd0) && (h > 16'sd0);
        c.x     = x[10:0];
        c.y     = y[10:0];
        c.x_end = 12'(x + w);
        c.y_end = 12'(y + h);
        return c;
    endfunction

endpackage

@@ rtl/core/crff_front.sv @@
// ----------------------------------------------------------------------------
// crff_front: command classifier
// Decodes the mode, drops unused codes and expands a start command into the
// geometry of its four parts before it enters the command queue.
// ----------------------------------------------------------------------------
module crff_front
(
    input  logic              push,
    input  crff_pkg::cmd_t    cmd,
    input  logic              q_full,
    output logic              q_push,
    output crff_pkg::entry_t  q_entry
);

    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [13:0] w;
    logic signed [13:0] h;
    logic signed [13:0] b;
    logic               known;

    always_comb
    begin
        x = {{2{cmd.origin_x[11]}}, cmd.origin_x};
        y = {{2{cmd.origin_y[11]}}, cmd.origin_y};
        w = {{2{cmd.extent_w[11]}}, cmd.extent_w};
        h = {{2{cmd.extent_h[11]}}, cmd.extent_h};
        b = $signed({3'b0, cmd.border_px});

        q_entry.color = cmd.fill_color;
        known         = 1'b1;
        case (cmd.mode)
            crff_pkg::MODE_RECT:
            begin
                q_entry.kind    = crff_pkg::KIND_RECT;
                q_entry.part_en = 4'b0001;
            end
            crff_pkg::MODE_FRAME:
            begin
                q_entry.kind    = crff_pkg::KIND_FRAME;
                q_entry.part_en = 4'b1111;
            end
            crff_pkg::MODE_STEP:
            begin
                q_entry.kind    = crff_pkg::KIND_STEP;
                q_entry.part_en = 4'b0000;
            end
            default:
            begin
                q_entry.kind    = crff_pkg::KIND_STEP;
                q_entry.part_en = 4'b0000;
                known           = 1'b0;
            end
        endcase

        // top, right, left, bottom; a plain rectangle is part 0 at full height
        q_entry.parts[0].x = x;
        q_entry.parts[0].y = y;
        q_entry.parts[0].w = w;
        q_entry.parts[0].h = (cmd.mode == crff_pkg::MODE_FRAME) ? b : h;
        q_entry.parts[1].x = x + w - b;
        q_entry.parts[1].y = y + b;
        q_entry.parts[1].w = b;
        q_entry.parts[1].h = h - b;
        q_entry.parts[2].x = x;
        q_entry.parts[2].y = y + b;
        q_entry.parts[2].w = b;
        q_entry.parts[2].h = h - b;
        q_entry.parts[3].x = x;
        q_entry.parts[3].y = y + h - b;
        q_entry.parts[3].w = w;
        q_entry.parts[3].h = b;

        q_push = push && !q_full && known;
    end

endmodule

@@ rtl/core/crff_queue.sv @@
// ----------------------------------------------------------------------------
// crff_queue: command queue between classifier and pixel walker
// Small register FIFO; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module crff_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  crff_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output crff_pkg::entry_t  head
);

    localparam int PTR_W = $clog2(DEPTH) + 1;

    crff_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;

    assign valid = (wr_ptr_reg != rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W-1] != rd_ptr_reg[PTR_W-1])
                && (wr_ptr_reg[PTR_W-2:0] == rd_ptr_reg[PTR_W-2:0]);
    assign head  = mem_reg[rd_ptr_reg[PTR_W-2:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[PTR_W-2:0]] <= push_entry;
        end
    end

endmodule

@@ rtl/core/crff_back.sv @@
// ----------------------------------------------------------------------------
// crff_back: pixel walker
// Clips the parts of the running command, walks the current part row by row
// and holds the result register.
// ----------------------------------------------------------------------------
module crff_back
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  crff_pkg::entry_t   q_head,
    output logic               q_pop,
    input  crff_pkg::mask_t    mask,
    output logic               empty,
    input  logic               pop,
    output crff_pkg::result_t  result,
    output crff_pkg::status_t  status
);

    localparam int NP = crff_pkg::NUM_PARTS;

    crff_pkg::part_t [NP-1:0] parts_reg, parts_next;
    logic [NP-1:0]      part_en_reg, part_en_next;
    logic [31:0]        color_reg, color_next;
    logic               load_pend_reg, load_pend_next;
    logic               busy_reg, busy_next;
    logic [1:0]         part_idx_reg, part_idx_next;
    logic [10:0]        col_reg, col_next;
    logic [10:0]        row_reg, row_next;
    logic [10:0]        span_start_reg, span_start_next;
    logic [11:0]        span_end_reg, span_end_next;
    logic [11:0]        rows_end_reg, rows_end_next;
    logic               out_valid_reg, out_valid_next;
    crff_pkg::result_t  out_reg, out_next;

    crff_pkg::clip_t    clip [NP];
    logic [NP-1:0]      cand;
    logic [NP-1:0]      sel_cand;
    logic               found;
    logic [1:0]         sel;
    logic               do_load;
    logic               step_fire;
    logic               out_free;
    logic [11:0]        col_plus;
    logic [11:0]        row_plus;

    // clip every part against the live mask, pick the next non-empty one
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            clip[i] = crff_pkg::clip_part(parts_reg[i], mask, 13'(SCREEN_WIDTH),
                                          13'(SCREEN_HEIGHT));
            cand[i] = clip[i].valid && part_en_reg[i];
            sel_cand[i] = cand[i] && (load_pend_reg || (2'(i) > part_idx_reg));
        end
        found = 1'b0;
        sel   = 2'd0;
        for (int i = NP - 1; i >= 0; i--)
        begin
            if (sel_cand[i])
            begin
                found = 1'b1;
                sel   = 2'(i);
            end
        end
    end

    always_comb
    begin
        parts_next      = parts_reg;
        part_en_next    = part_en_reg;
        color_next      = color_reg;
        load_pend_next  = load_pend_reg;
        busy_next       = busy_reg;
        part_idx_next   = part_idx_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        span_start_next = span_start_reg;
        span_end_next   = span_end_reg;
        rows_end_next   = rows_end_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        q_pop           = 1'b0;
        step_fire       = 1'b0;
        do_load         = 1'b0;
        out_free        = !out_valid_reg || pop;
        col_plus        = {1'b0, col_reg} + 12'd1;
        row_plus        = {1'b0, row_reg} + 12'd1;

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        if (load_pend_reg)
        begin
            load_pend_next = 1'b0;
            do_load        = 1'b1;
        end
        else if (q_valid)
        begin
            case (q_head.kind)
                crff_pkg::KIND_RECT, crff_pkg::KIND_FRAME:
                begin
                    // abandons any running command
                    q_pop          = 1'b1;
                    parts_next     = q_head.parts;
                    part_en_next   = q_head.part_en;
                    color_next     = q_head.color;
                    busy_next      = 1'b0;
                    load_pend_next = 1'b1;
                end
                crff_pkg::KIND_STEP:
                begin
                    if (!busy_reg)
                    begin
                        q_pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        q_pop     = 1'b1;
                        step_fire = 1'b1;
                        if (col_plus >= span_end_reg)
                        begin
                            col_next = span_start_reg;
                            if (row_plus >= rows_end_reg)
                            begin
                                do_load = 1'b1;
                            end
                            else
                            begin
                                row_next = row_plus[10:0];
                            end
                        end
                        else
                        begin
                            col_next = col_plus[10:0];
                        end
                    end
                end
                default:
                begin
                    q_pop = 1'b1;
                end
            endcase
        end

        if (do_load)
        begin
            busy_next = found;
            if (found)
            begin
                part_idx_next   = sel;
                span_start_next = clip[sel].x;
                span_end_next   = clip[sel].x_end;
                rows_end_next   = clip[sel].y_end;
                col_next        = clip[sel].x;
                row_next        = clip[sel].y;
            end
        end

        if (step_fire)
        begin
            out_valid_next       = 1'b1;
            out_next.write_valid = 1'b1;
            out_next.pixel_x     = col_reg;
            out_next.pixel_y     = row_reg;
            out_next.pixel_value = color_reg;
            out_next.last_write  = do_load && !found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pend_reg <= 1'b0;
            busy_reg      <= 1'b0;
            part_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
            part_en_reg   <= '0;
        end
        else
        begin
            load_pend_reg <= load_pend_next;
            busy_reg      <= busy_next;
            part_idx_reg  <= part_idx_next;
            out_valid_reg <= out_valid_next;
            part_en_reg   <= part_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        parts_reg      <= parts_next;
        color_reg      <= color_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        span_start_reg <= span_start_next;
        span_end_reg   <= span_end_next;
        rows_end_reg   <= rows_end_next;
        out_reg        <= out_next;
    end

    assign empty            = !out_valid_reg;
    assign result           = out_reg;
    assign status.busy      = busy_reg;
    assign status.load_pend = load_pend_reg;
    assign status.step_fire = step_fire;
    assign status.last      = out_next.last_write;

endmodule

@@ rtl/core/clipped_rect_frame_fill.sv @@
// ----------------------------------------------------------------------------
// clipped_rect_frame_fill: clipped rectangle and frame fill engine
// Start commands latch a rectangle or a four-part frame; step commands emit
// one clipped pixel write each while a part is loaded, in row-major order per part.
//
//   channel   handshake        payload
//   command   push / full      cmd    (crff_pkg::cmd_t)
//   result    empty / pop      result (crff_pkg::result_t)
//   config    cfg_we           cfg_addr, cfg_data
//
// Steps run at one item per cycle when results are popped every cycle.
// A start command holds the walker while it latches the part geometry, then
// clips all parts and loads the first non-empty one.
// The command queue (QUEUE_DEPTH items) lets commands in while the result
// register is stalled. Reset clears the walker state and queue pointers.
// ----------------------------------------------------------------------------
module clipped_rect_frame_fill
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int QUEUE_DEPTH   = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  crff_pkg::cmd_t     cmd,
    output logic               empty,
    input  logic               pop,
    output crff_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [11:0]        cfg_data
);

    crff_pkg::mask_t   mask_reg;
    crff_pkg::entry_t  q_entry;
    crff_pkg::entry_t  q_head;
    crff_pkg::status_t status;
    logic              q_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg.left   <= 11'd0;
            mask_reg.top    <= 11'd0;
            mask_reg.width  <= 12'd800;
            mask_reg.height <= 12'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                crff_pkg::REG_MASK_LEFT:   mask_reg.left   <= cfg_data[10:0];
                crff_pkg::REG_MASK_TOP:    mask_reg.top    <= cfg_data[10:0];
                crff_pkg::REG_MASK_WIDTH:  mask_reg.width  <= cfg_data;
                crff_pkg::REG_MASK_HEIGHT: mask_reg.height <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign full = q_full;

    crff_front u_front
    (
        .push    (push),
        .cmd     (cmd),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    crff_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    crff_back
    #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .mask    (mask_reg),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .status  (status)
    );

    // the final write of a command leaves the walker idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.step_fire && status.last |=> !status.busy)
        else $error("walker still busy after last write");

    // a pixel is only emitted from a loaded part
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.step_fire |-> status.busy && !status.load_pend)
        else $error("pixel emitted without a loaded part");

    // a pending part load is cleared in the next cycle
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        status.load_pend |=> !status.load_pend)
        else $error("part load pending for more than one cycle");

    // classifier never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full command queue");

endmodule

@@ dv/clipped_rect_frame_fill_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_rect_frame_fill_tb: self-checking bench for the rectangle fill engine
// A directed table covers clipping extremes, empty parts, idle and unused
// commands and a mask change in the middle of a frame. Random phases follow,
// each under its own mask box. Every popped pixel write is checked against
// an in-bench model of the clipper and pixel walker.
// ----------------------------------------------------------------------------
module clipped_rect_frame_fill_tb;

    localparam int SCR_W        = 800;
    localparam int SCR_H        = 480;
    localparam int IDLE_PCT     = 17;
    localparam int SETTLE       = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_ITEMS   = 2000;
    localparam int MAX_RUN      = 40;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum {ROW_PREDICT, ROW_NONE, ROW_WRITE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        crff_pkg::cmd_t      c;
        int                  reps;
        crff_pkg::result_t   want;
        logic [1:0]          addr;
        logic [11:0]         data;
    } stim_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              push     = 1'b0;
    logic              full;
    crff_pkg::cmd_t    cmd      = '0;
    logic              empty;
    logic              pop      = 1'b0;
    crff_pkg::result_t result;
    logic              cfg_we   = 1'b0;
    logic [1:0]        cfg_addr = crff_pkg::REG_MASK_LEFT;
    logic [11:0]       cfg_data = '0;

    int cycle          = 0;
    int mismatch_count = 0;
    wire quiet = (cycle >= 1500) && (cycle < 3500);

    crff_pkg::result_t expected_writes[$];

    // model of the mask registers and the pixel walker
    int clip_left   = 0;
    int clip_top    = 0;
    int clip_width  = 800;
    int clip_height = 480;
    bit walk_busy   = 1'b0;
    bit walk_frame  = 1'b0;
    int walk_part   = 0;
    int walk_col    = 0;
    int walk_row    = 0;
    int span_lo     = 0;
    int span_hi     = 0;
    int row_hi      = 0;
    int geo_x       = 0;
    int geo_y       = 0;
    int geo_w       = 0;
    int geo_h       = 0;
    int geo_b       = 0;
    logic [31:0] walk_color = '0;

    clipped_rect_frame_fill
    #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    )
    DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pop <= rst_n && (quiet || ($urandom_range(99) >= IDLE_PCT));
    end

    // geometry of one part, clipped to mask and screen; 1 if it covers pixels
    function automatic bit fit_part(input int idx, output int px, output int py,
                                    output int pw, output int ph);
        int x;
        int y;
        int w;
        int h;
        int mr;
        int mb;
        bit keep;
        case (idx)
            0:
            begin
                x = geo_x; y = geo_y; w = geo_w; h = walk_frame ? geo_b : geo_h;
            end
            1:
            begin
                x = geo_x + geo_w - geo_b; y = geo_y + geo_b; w = geo_b; h = geo_h - geo_b;
            end
            2:
            begin
                x = geo_x; y = geo_y + geo_b; w = geo_b; h = geo_h - geo_b;
            end
            default:
            begin
                x = geo_x; y = geo_y + geo_h - geo_b; w = geo_w; h = geo_b;
            end
        endcase
        mr = clip_left + clip_width;
        mb = clip_top + clip_height;
        if (x < clip_left)
        begin
            w = w - (clip_left - x);
            x = clip_left;
        end
        if (y < clip_top)
        begin
            h = h - (clip_top - y);
            y = clip_top;
        end
        keep = !((x > SCR_W) || (y > SCR_H));
        if (x + w > mr)
            w = mr - x;
        if (y + h > mb)
            h = mb - y;
        if (x + w > SCR_W)
            w = SCR_W - x;
        if (y + h > SCR_H)
            h = SCR_H - y;
        px = x;
        py = y;
        pw = w;
        ph = h;
        return keep && (w > 0) && (h > 0);
    endfunction

    // load the first non-empty part at or after first; idle if none left
    function automatic void seek_part(input int first);
        int i;
        int x;
        int y;
        int w;
        int h;
        int count;
        count = walk_frame ? 4 : 1;
        walk_busy = 1'b0;
        for (i = first; i < count && !walk_busy; i++)
        begin
            if (fit_part(i, x, y, w, h))
            begin
                walk_part = i;
                span_lo   = x;
                span_hi   = x + w;
                row_hi    = y + h;
                walk_col  = x;
                walk_row  = y;
                walk_busy = 1'b1;
            end
        end
    endfunction

    // advance the model by one accepted item; 1 when it yields a pixel write
    function automatic bit predict_write(input crff_pkg::cmd_t c,
                                         output crff_pkg::result_t r);
        bit hit;
        hit = 1'b0;
        r   = '0;
        case (c.mode)
            crff_pkg::MODE_RECT, crff_pkg::MODE_FRAME:
            begin
                walk_frame = (c.mode == crff_pkg::MODE_FRAME);
                geo_x      = $signed(c.origin_x);
                geo_y      = $signed(c.origin_y);
                geo_w      = $signed(c.extent_w);
                geo_h      = $signed(c.extent_h);
                geo_b      = int'(c.border_px);
                walk_color = c.fill_color;
                seek_part(0);
            end
            crff_pkg::MODE_STEP:
            begin
                if (walk_busy)
                begin
                    hit           = 1'b1;
                    r.write_valid = 1'b1;
                    r.pixel_x     = 11'(walk_col);
                    r.pixel_y     = 11'(walk_row);
                    r.pixel_value = walk_color;
                    walk_col++;
                    if (walk_col >= span_hi)
                    begin
                        walk_col = span_lo;
                        walk_row++;
                        if (walk_row >= row_hi)
                            seek_part(walk_part + 1);
                    end
                    r.last_write = !walk_busy;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        crff_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_writes.size() == 0)
            begin
                $display("%0t: unexpected write, expected none, actual x=%0d y=%0d v=%0h",
                         $time, result.pixel_x, result.pixel_y, result.pixel_value);
                mismatch_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                check_field("write_valid", 32'(want.write_valid), 32'(result.write_valid));
                check_field("pixel_x", 32'(want.pixel_x), 32'(result.pixel_x));
                check_field("pixel_y", 32'(want.pixel_y), 32'(result.pixel_y));
                check_field("pixel_value", want.pixel_value, result.pixel_value);
                check_field("last_write", 32'(want.last_write), 32'(result.last_write));
            end
        end
    end

    // present one item and return at the edge where it is taken
    task automatic offer_cmd(input crff_pkg::cmd_t c);
        while (!quiet && ($urandom_range(99) < IDLE_PCT))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cmd  <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // let every expected write arrive, then give queued starts time to finish
    task automatic drain();
        push <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [11:0] data);
        drain();
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            crff_pkg::REG_MASK_LEFT:   clip_left   = int'(data[10:0]);
            crff_pkg::REG_MASK_TOP:    clip_top    = int'(data[10:0]);
            crff_pkg::REG_MASK_WIDTH:  clip_width  = int'(data);
            crff_pkg::REG_MASK_HEIGHT: clip_height = int'(data);
            default: ;
        endcase
    endtask

    function automatic stim_row_t cmd_row(input row_kind_t k, input logic [1:0] mode,
                                          input int x, input int y, input int w,
                                          input int h, input int b,
                                          input logic [31:0] color, input int reps,
                                          input int ex = 0, input int ey = 0);
        stim_row_t r;
        r.kind               = k;
        r.c.mode             = mode;
        r.c.origin_x         = 12'(x);
        r.c.origin_y         = 12'(y);
        r.c.extent_w         = 12'(w);
        r.c.extent_h         = 12'(h);
        r.c.border_px        = 11'(b);
        r.c.fill_color       = color;
        r.reps               = reps;
        r.want.write_valid   = 1'b1;
        r.want.pixel_x       = 11'(ex);
        r.want.pixel_y       = 11'(ey);
        r.want.pixel_value   = color;
        r.want.last_write    = 1'b1;
        r.addr               = crff_pkg::REG_MASK_LEFT;
        r.data               = '0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] addr, input logic [11:0] data);
        stim_row_t r;
        r      = cmd_row(ROW_CFG, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, '0, 0);
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    initial
    begin
        stim_row_t         plan[$];
        crff_pkg::mask_t   mask_plan[$];
        crff_pkg::mask_t   mk;
        crff_pkg::cmd_t    c;
        crff_pkg::result_t r;
        bit                hit;
        int                k;
        int                n;
        int                p;
        int                run_len;
        int                per_phase;

        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 1));
        plan.push_back(cmd_row(ROW_NONE, MODE_UNUSED, -1, -1, -1, -1, 2047, 'hFFFFFFFF, 1));
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_RECT, 0, 0, 1, 1, 0, 'hFFFFFFFF, 1));
        plan.push_back(cmd_row(ROW_WRITE, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'hFFFFFFFF, 1,
                               0, 0));
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 1));
        // far corner, extent cut back to a single pixel
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_RECT, 799, 479, 2047, 2047, 2047,
                               'h0, 1));
        plan.push_back(cmd_row(ROW_WRITE, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 1,
                               799, 479));
        // extent goes negative after moving onto the mask
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_RECT, -2048, -2048, 2047, 2047, 0,
                               'hA5A5A5A5, 1));
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 1));
        // origin beyond the screen
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_RECT, 2047, 2047, 4, 4, 0,
                               'h5A5A5A5A, 1));
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 1));
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_RECT, 5, 5, -2048, -2048, 0, 'h1, 1));
        // new frame abandons a running rectangle; some frame parts are empty
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_RECT, 100, 200, 4, 3, 0,
                               'h12345678, 1));
        plan.push_back(cmd_row(ROW_PREDICT, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 2));
        plan.push_back(cmd_row(ROW_PREDICT, crff_pkg::MODE_FRAME, -1, -1, 3, 3, 1,
                               'h87654321, 1));
        plan.push_back(cmd_row(ROW_PREDICT, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 5));
        // zero border: nothing visible
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_FRAME, 50, 50, 8, 8, 0,
                               'hCAFEF00D, 1));
        plan.push_back(cmd_row(ROW_NONE, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 1));
        // mask moves while a frame is half drawn
        plan.push_back(cmd_row(ROW_PREDICT, crff_pkg::MODE_FRAME, 0, 0, 2, 3, 1,
                               'h0F0F0F0F, 1));
        plan.push_back(cmd_row(ROW_PREDICT, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 2));
        plan.push_back(cfg_row(crff_pkg::REG_MASK_LEFT, 12'd1));
        plan.push_back(cmd_row(ROW_PREDICT, crff_pkg::MODE_STEP, 0, 0, 0, 0, 0, 'h0, 3));
        plan.push_back(cfg_row(crff_pkg::REG_MASK_LEFT, 12'd0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].addr, plan[i].data);
            else
            begin
                for (k = 0; k < plan[i].reps; k++)
                begin
                    offer_cmd(plan[i].c);
                    hit = predict_write(plan[i].c, r);
                    if (plan[i].kind == ROW_WRITE)
                        expected_writes.push_back(plan[i].want);
                    else if (plan[i].kind == ROW_PREDICT && hit)
                        expected_writes.push_back(r);
                end
            end
        end

        // mask boxes: defaults, extremes, then random
        mask_plan.push_back('{left: 11'd0,    top: 11'd0,    width: 12'd800,  height: 12'd480});
        mask_plan.push_back('{left: 11'd0,    top: 11'd0,    width: 12'd2048, height: 12'd2048});
        mask_plan.push_back('{left: 11'd0,    top: 11'd0,    width: 12'd0,    height: 12'd0});
        mask_plan.push_back('{left: 11'd2047, top: 11'd2047, width: 12'd2048, height: 12'd2048});
        mask_plan.push_back('{left: 11'd790,  top: 11'd470,  width: 12'd2048, height: 12'd2048});
        for (p = 0; p < 5; p++)
        begin
            mk.left   = 11'($urandom_range(0, 810));
            mk.top    = 11'($urandom_range(0, 490));
            mk.width  = ($urandom_range(3) == 0) ? 12'd2048 : 12'($urandom_range(0, 40));
            mk.height = ($urandom_range(3) == 0) ? 12'd2048 : 12'($urandom_range(0, 40));
            mask_plan.push_back(mk);
        end
        per_phase = RAND_ITEMS / mask_plan.size();

        foreach (mask_plan[i])
        begin
            write_reg(crff_pkg::REG_MASK_LEFT, 12'(mask_plan[i].left));
            write_reg(crff_pkg::REG_MASK_TOP, 12'(mask_plan[i].top));
            write_reg(crff_pkg::REG_MASK_WIDTH, mask_plan[i].width);
            write_reg(crff_pkg::REG_MASK_HEIGHT, mask_plan[i].height);
            n = 0;
            run_len = 0;
            while (n < per_phase)
            begin
                c.mode       = 2'($urandom_range(0, 3));
                c.origin_x   = 12'($urandom);
                c.origin_y   = 12'($urandom);
                c.extent_w   = 12'($urandom);
                c.extent_h   = 12'($urandom);
                c.border_px  = 11'($urandom);
                c.fill_color = $urandom;
                if (walk_busy && run_len < MAX_RUN && $urandom_range(99) < 92)
                begin
                    c.mode = crff_pkg::MODE_STEP;
                end
                else
                begin
                    run_len = 0;
                    // mostly small shapes placed around the mask origin
                    if ($urandom_range(99) < 85)
                    begin
                        c.mode      = $urandom_range(1) ? crff_pkg::MODE_FRAME
                                                        : crff_pkg::MODE_RECT;
                        c.origin_x  = 12'(clip_left + int'($urandom_range(0, 16)) - 8);
                        c.origin_y  = 12'(clip_top + int'($urandom_range(0, 16)) - 8);
                        c.extent_w  = 12'(int'($urandom_range(0, 14)) - 2);
                        c.extent_h  = 12'(int'($urandom_range(0, 14)) - 2);
                        c.border_px = 11'($urandom_range(0, 4));
                    end
                end
                if (c.mode == crff_pkg::MODE_RECT || c.mode == crff_pkg::MODE_FRAME
                    || (c.mode == crff_pkg::MODE_STEP && walk_busy))
                    n++;
                run_len++;
                offer_cmd(c);
                if (predict_write(c, r))
                    expected_writes.push_back(r);
            end
        end

        drain();
        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/crff_pkg.sv
rtl/core/crff_front.sv
rtl/core/crff_queue.sv
rtl/core/crff_back.sv
rtl/core/clipped_rect_frame_fill.sv
dv/clipped_rect_frame_fill_tb.sv
